@@ rtl/core/bmfm_pkg.sv @@
// Shared types and constants for the battery module fault monitor.
`timescale 1ns / 1ps
`default_nettype none

package bmfm_pkg;

    // Input mode codes (s_tuser)
    localparam logic [1:0] MODE_REPORT      = 2'd0;
    localparam logic [1:0] MODE_REPORT_TEMP = 2'd1;
    localparam logic [1:0] MODE_TICK        = 2'd2;

    // Result kinds (m_tuser)
    localparam logic [1:0] KIND_VERDICT = 2'd0;
    localparam logic [1:0] KIND_INVALID = 2'd1;
    localparam logic [1:0] KIND_SILENT  = 2'd2;

    // Fault codes
    localparam logic [1:0] FAULT_NONE      = 2'd0;
    localparam logic [1:0] FAULT_IMBALANCE = 2'd1;
    localparam logic [1:0] FAULT_LIMIT     = 2'd2;

    // Register indexes
    localparam logic [2:0] REG_VOLTAGE_LIMIT   = 3'd0;
    localparam logic [2:0] REG_CURRENT_LIMIT   = 3'd1;
    localparam logic [2:0] REG_TEMP_LIMIT      = 3'd2;
    localparam logic [2:0] REG_IMBALANCE_LIMIT = 3'd3;
    localparam logic [2:0] REG_SILENCE_TIMEOUT = 3'd4;
    localparam logic [2:0] REG_OWN_MODULE      = 3'd5;

    localparam int PADDR_W    = 5;
    localparam int S_TDATA_W  = 88;
    localparam int M_TDATA_W  = 16;

    typedef struct packed {
        logic [14:0] voltage_limit;
        logic [14:0] current_limit;
        logic [15:0] temp_limit;
        logic [14:0] imbalance_limit;
        logic [15:0] silence_timeout;
        logic [7:0]  own_module;
    } cfg_t;

    typedef enum logic [4:0] {
        ST_IDLE    = 5'b00001,
        ST_CHECK   = 5'b00010,
        ST_VERDICT = 5'b00100,
        ST_TICK    = 5'b01000,
        ST_FLUSH   = 5'b10000
    } state_t;

    typedef struct packed {
        logic capture;
        logic check;
        logic emit_verdict;
        logic tick_step;
        logic flush;
    } cmd_t;

    typedef struct packed {
        logic slot_free;
        logic tick_stall;
        logic idx_last;
        logic pend_valid;
    } sts_t;

endpackage

`default_nettype wire

@@ rtl/core/bmfm_regs.sv @@
// APB configuration registers of the fault monitor.
`timescale 1ns / 1ps
`default_nettype none

module bmfm_regs (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [bmfm_pkg::PADDR_W-1:0] paddr,
    input  wire logic [31:0]                  pwdata,
    output logic      [31:0]                  prdata,
    output logic                              pready,
    output bmfm_pkg::cfg_t                    cfg
);

    bmfm_pkg::cfg_t cfg_reg;
    logic [2:0]     rindex;
    logic           wr_en;

    assign pready = 1'b1;
    assign rindex = paddr[4:2];
    assign wr_en  = psel && penable && pwrite && pready;
    assign cfg    = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.voltage_limit   <= 15'd4000;
            cfg_reg.current_limit   <= 15'd2000;
            cfg_reg.temp_limit      <= 16'd4500;
            cfg_reg.imbalance_limit <= 15'd100;
            cfg_reg.silence_timeout <= 16'd3000;
            cfg_reg.own_module      <= 8'd2;
        end else if (wr_en) begin
            case (rindex)
                bmfm_pkg::REG_VOLTAGE_LIMIT:   cfg_reg.voltage_limit   <= pwdata[14:0];
                bmfm_pkg::REG_CURRENT_LIMIT:   cfg_reg.current_limit   <= pwdata[14:0];
                bmfm_pkg::REG_TEMP_LIMIT:      cfg_reg.temp_limit      <= pwdata[15:0];
                bmfm_pkg::REG_IMBALANCE_LIMIT: cfg_reg.imbalance_limit <= pwdata[14:0];
                bmfm_pkg::REG_SILENCE_TIMEOUT: cfg_reg.silence_timeout <= pwdata[15:0];
                bmfm_pkg::REG_OWN_MODULE:      cfg_reg.own_module      <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (rindex)
            bmfm_pkg::REG_VOLTAGE_LIMIT:   prdata = {17'd0, cfg_reg.voltage_limit};
            bmfm_pkg::REG_CURRENT_LIMIT:   prdata = {17'd0, cfg_reg.current_limit};
            bmfm_pkg::REG_TEMP_LIMIT:      prdata = {{16{cfg_reg.temp_limit[15]}},
                                                     cfg_reg.temp_limit};
            bmfm_pkg::REG_IMBALANCE_LIMIT: prdata = {17'd0, cfg_reg.imbalance_limit};
            bmfm_pkg::REG_SILENCE_TIMEOUT: prdata = {16'd0, cfg_reg.silence_timeout};
            bmfm_pkg::REG_OWN_MODULE:      prdata = {24'd0, cfg_reg.own_module};
            default:                       prdata = 32'd0;
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/core/bmfm_ctrl.sv @@
// Controller state machine of the fault monitor.
`timescale 1ns / 1ps
`default_nettype none

module bmfm_ctrl (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [1:0] s_tuser,
    input  bmfm_pkg::sts_t  sts,
    output bmfm_pkg::cmd_t  cmd
);

    bmfm_pkg::state_t state_reg, state_next;
    logic             accept;

    assign s_tready = (state_reg == bmfm_pkg::ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        cmd              = '0;
        cmd.capture      = accept;
        cmd.check        = (state_reg == bmfm_pkg::ST_CHECK);
        cmd.emit_verdict = (state_reg == bmfm_pkg::ST_VERDICT) && sts.slot_free;
        cmd.tick_step    = (state_reg == bmfm_pkg::ST_TICK) && !sts.tick_stall;
        cmd.flush        = (state_reg == bmfm_pkg::ST_FLUSH) && sts.pend_valid &&
                           sts.slot_free;
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            bmfm_pkg::ST_IDLE: begin
                if (accept) begin
                    if (s_tuser == bmfm_pkg::MODE_TICK) begin
                        state_next = bmfm_pkg::ST_TICK;
                    end else if (s_tuser == bmfm_pkg::MODE_REPORT ||
                                 s_tuser == bmfm_pkg::MODE_REPORT_TEMP) begin
                        state_next = bmfm_pkg::ST_CHECK;
                    end
                end
            end
            bmfm_pkg::ST_CHECK: begin
                state_next = bmfm_pkg::ST_VERDICT;
            end
            bmfm_pkg::ST_VERDICT: begin
                if (sts.slot_free) begin
                    state_next = bmfm_pkg::ST_IDLE;
                end
            end
            bmfm_pkg::ST_TICK: begin
                if (!sts.tick_stall && sts.idx_last) begin
                    state_next = bmfm_pkg::ST_FLUSH;
                end
            end
            bmfm_pkg::ST_FLUSH: begin
                if (!sts.pend_valid || sts.slot_free) begin
                    state_next = bmfm_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = bmfm_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= bmfm_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/bmfm_dp.sv @@
// Datapath of the fault monitor: limit checks, silence timers, result register.
`timescale 1ns / 1ps
`default_nettype none

module bmfm_dp #(
    parameter int MODULE_COUNT = 2
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  bmfm_pkg::cfg_t                      cfg,
    input  bmfm_pkg::cmd_t                      cmd,
    output bmfm_pkg::sts_t                      sts,
    input  wire logic [bmfm_pkg::S_TDATA_W-1:0] s_tdata,
    input  wire logic [1:0]                     s_tuser,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic      [bmfm_pkg::M_TDATA_W-1:0] m_tdata,
    output logic      [1:0]                     m_tuser,
    output logic                                m_tlast
);

    localparam int IDX_W = (MODULE_COUNT > 1) ? $clog2(MODULE_COUNT) : 1;

    // captured item
    logic [7:0]         mod_reg;
    logic signed [15:0] a_reg, b_reg, c_reg, cur_reg, tmp_reg;
    logic               temp_en_reg;

    // verdict stage
    logic inval_reg, lim_fault_reg, imb_fault_reg, rest_reg;

    // module state
    logic [15:0]             count_reg [MODULE_COUNT];
    logic [MODULE_COUNT-1:0] failed_reg;

    // tick walk
    logic [IDX_W-1:0] idx_reg;
    logic             pend_valid_reg;
    logic [7:0]       pend_mod_reg;

    // result register
    logic       out_valid_reg;
    logic [1:0] out_kind_reg;
    logic [7:0] out_mod_reg;
    logic       out_healthy_reg;
    logic [1:0] out_code_reg;
    logic       out_rest_reg;
    logic       out_last_reg;

    logic               slot_free;
    logic               mod_ok;
    logic [7:0]         mod_dec;
    logic [IDX_W-1:0]   rix;
    logic signed [16:0] vl, cl, il, spread;
    logic signed [15:0] hi, lo;
    logic               lim_fault, imb_fault;
    logic [7:0]         tick_mod;
    logic               exempt;
    logic [15:0]        cnt_cur, cnt_inc;
    logic               newfail;
    logic               pend_emit;

    assign slot_free = !out_valid_reg || m_tready;

    // report checks
    assign mod_ok  = (mod_reg != 8'd0) && (mod_reg <= 8'(MODULE_COUNT));
    assign mod_dec = mod_reg - 8'd1;
    assign rix     = mod_dec[IDX_W-1:0];
    assign vl      = $signed({2'b00, cfg.voltage_limit});
    assign cl      = $signed({2'b00, cfg.current_limit});
    assign il      = $signed({2'b00, cfg.imbalance_limit});

    always_comb begin
        hi = a_reg;
        lo = a_reg;
        if (b_reg > hi) hi = b_reg;
        if (c_reg > hi) hi = c_reg;
        if (b_reg < lo) lo = b_reg;
        if (c_reg < lo) lo = c_reg;
    end

    assign spread    = $signed({hi[15], hi}) - $signed({lo[15], lo});
    assign lim_fault = ($signed({a_reg[15], a_reg}) > vl) ||
                       ($signed({b_reg[15], b_reg}) > vl) ||
                       ($signed({c_reg[15], c_reg}) > vl) ||
                       ($signed({cur_reg[15], cur_reg}) > cl) ||
                       (temp_en_reg && !(tmp_reg < $signed(cfg.temp_limit)));
    assign imb_fault = spread > il;

    // tick checks
    assign tick_mod  = 8'(idx_reg) + 8'd1;
    assign exempt    = (tick_mod == cfg.own_module);
    assign cnt_cur   = count_reg[idx_reg];
    assign cnt_inc   = (cnt_cur == 16'hFFFF) ? cnt_cur : cnt_cur + 16'd1;
    assign newfail   = !exempt && (cnt_inc > cfg.silence_timeout) && !failed_reg[idx_reg];
    assign pend_emit = cmd.tick_step && newfail && pend_valid_reg;

    assign sts.slot_free  = slot_free;
    assign sts.tick_stall = newfail && pend_valid_reg && !slot_free;
    assign sts.idx_last   = (idx_reg == IDX_W'(MODULE_COUNT - 1));
    assign sts.pend_valid = pend_valid_reg;

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            mod_reg     <= s_tdata[7:0];
            a_reg       <= s_tdata[23:8];
            b_reg       <= s_tdata[39:24];
            c_reg       <= s_tdata[55:40];
            cur_reg     <= s_tdata[71:56];
            tmp_reg     <= s_tdata[87:72];
            temp_en_reg <= (s_tuser == bmfm_pkg::MODE_REPORT_TEMP);
        end
        if (cmd.check) begin
            inval_reg     <= !mod_ok;
            lim_fault_reg <= lim_fault;
            imb_fault_reg <= imb_fault;
            rest_reg      <= failed_reg[rix];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < MODULE_COUNT; i++) begin
                count_reg[i] <= 16'd0;
            end
            failed_reg     <= '0;
            idx_reg        <= '0;
            pend_valid_reg <= 1'b0;
            pend_mod_reg   <= 8'd0;
        end else begin
            if (cmd.capture) begin
                idx_reg <= '0;
            end
            if (cmd.check && mod_ok) begin
                count_reg[rix]  <= 16'd0;
                failed_reg[rix] <= 1'b0;
            end
            if (cmd.tick_step) begin
                idx_reg <= idx_reg + 1'b1;
                if (!exempt) begin
                    count_reg[idx_reg] <= cnt_inc;
                end
                if (newfail) begin
                    failed_reg[idx_reg] <= 1'b1;
                    pend_valid_reg      <= 1'b1;
                    pend_mod_reg        <= tick_mod;
                end
            end
            if (cmd.flush) begin
                pend_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.emit_verdict || pend_emit || cmd.flush) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit_verdict) begin
            out_kind_reg    <= inval_reg ? bmfm_pkg::KIND_INVALID : bmfm_pkg::KIND_VERDICT;
            out_mod_reg     <= inval_reg ? mod_reg : cfg.own_module;
            out_healthy_reg <= !inval_reg && !lim_fault_reg && !imb_fault_reg;
            out_code_reg    <= (inval_reg)     ? bmfm_pkg::FAULT_NONE :
                               (lim_fault_reg) ? bmfm_pkg::FAULT_LIMIT :
                               (imb_fault_reg) ? bmfm_pkg::FAULT_IMBALANCE :
                                                 bmfm_pkg::FAULT_NONE;
            out_rest_reg    <= !inval_reg && rest_reg;
            out_last_reg    <= 1'b1;
        end else if (pend_emit || cmd.flush) begin
            out_kind_reg    <= bmfm_pkg::KIND_SILENT;
            out_mod_reg     <= pend_mod_reg;
            out_healthy_reg <= 1'b0;
            out_code_reg    <= bmfm_pkg::FAULT_NONE;
            out_rest_reg    <= 1'b0;
            out_last_reg    <= cmd.flush;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0, out_rest_reg, out_code_reg, out_healthy_reg, out_mod_reg};
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

endmodule

`default_nettype wire

@@ rtl/core/battery_module_fault_monitor.sv @@
// Top level of the battery module fault monitor.
`timescale 1ns / 1ps
`default_nettype none

// Checks reports from battery modules 1..MODULE_COUNT against the programmed voltage,
// current, temperature and cell imbalance limits and tracks a silence timer per module.
// One input transfer is taken at a time. A report (mode 0 or 1) gives one result
// from ST_VERDICT when the output is free; the next transfer can be accepted in the
// same cycle as that result appears. A tick (mode 2) walks the module timers one
// module per cycle while no output stall holds it; each newly silent module gives
// one result, the final one carrying tlast. Mode 3 is dropped. The result register
// lets the next transfer be accepted while a result waits on m_tready.

module battery_module_fault_monitor #(
    parameter int MODULE_COUNT = 2
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // APB configuration
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [bmfm_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [31:0]                    pwdata,
    output logic      [31:0]                    prdata,
    output logic                                pready,
    // input stream
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // module_number[7:0], cell_a_mv[23:8], cell_b_mv[39:24], cell_c_mv[55:40],
    // current_ma[71:56], temperature_cdeg[87:72]
    input  wire logic [bmfm_pkg::S_TDATA_W-1:0] s_tdata,
    // mode[1:0]
    input  wire logic [1:0]                     s_tuser,
    // result stream
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // module_out[7:0], healthy[8], fault_code[10:9], restored[11], zero[15:12]
    output logic      [bmfm_pkg::M_TDATA_W-1:0] m_tdata,
    // kind[1:0]
    output logic      [1:0]                     m_tuser,
    output logic                                m_tlast
);

    bmfm_pkg::cfg_t cfg;
    bmfm_pkg::cmd_t cmd;
    bmfm_pkg::sts_t sts;

    bmfm_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    bmfm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .sts      (sts),
        .cmd      (cmd)
    );

    bmfm_dp #(
        .MODULE_COUNT (MODULE_COUNT)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .cmd      (cmd),
        .sts      (sts),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
// Self-checking testbench for the battery module fault monitor: predicts every result and checks it.
`timescale 1ns / 1ps

module tb_top;

    localparam int         MODULE_COUNT  = 2;
    localparam logic [1:0] MODE_UNUSED   = 2'd3;
    localparam int         SETTLE_CYCLES = 16;
    localparam int         LONG_HOLD     = 300;
    localparam int         IDLE_LIMIT    = 5000;
    localparam int         REPORT_LIMIT  = 10;
    localparam int         SW            = bmfm_pkg::S_TDATA_W;
    localparam int         MW            = bmfm_pkg::M_TDATA_W;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] module_out;
        logic       healthy;
        logic [1:0] fault;
        logic       restored;
        logic       is_last;
    } monitor_result_t;

    class fault_scoreboard;
        logic [14:0]        voltage_limit;
        logic [14:0]        current_limit;
        logic signed [15:0] temp_limit;
        logic [14:0]        imbalance_limit;
        logic [15:0]        silence_timeout;
        logic [7:0]         own_module;
        logic [15:0]        silence_count [MODULE_COUNT];
        logic               failed_mark   [MODULE_COUNT];
        monitor_result_t    expected_results [$];
        int                 mismatches;

        function new();
            voltage_limit   = 15'd4000;
            current_limit   = 15'd2000;
            temp_limit      = 16'sd4500;
            imbalance_limit = 15'd100;
            silence_timeout = 16'd3000;
            own_module      = 8'd2;
            foreach (silence_count[i]) begin
                silence_count[i] = '0;
                failed_mark[i]   = 1'b0;
            end
            mismatches = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [31:0] value);
            case (idx)
                bmfm_pkg::REG_VOLTAGE_LIMIT:   voltage_limit   = value[14:0];
                bmfm_pkg::REG_CURRENT_LIMIT:   current_limit   = value[14:0];
                bmfm_pkg::REG_TEMP_LIMIT:      temp_limit      = value[15:0];
                bmfm_pkg::REG_IMBALANCE_LIMIT: imbalance_limit = value[14:0];
                bmfm_pkg::REG_SILENCE_TIMEOUT: silence_timeout = value[15:0];
                bmfm_pkg::REG_OWN_MODULE:      own_module      = value[7:0];
                default: ;
            endcase
        endfunction

        function void push_result(logic [1:0] kind, logic [7:0] module_out, logic healthy,
                                  logic [1:0] fault, logic restored);
            monitor_result_t r;
            r = '{kind, module_out, healthy, fault, restored, 1'b0};
            expected_results.push_back(r);
        endfunction

        // predicts the results of one accepted input transfer
        function void accept_item(logic [1:0] mode, logic [SW-1:0] data);
            logic [7:0] number;
            int         cell_a, cell_b, cell_c, current, temperature, top, bottom, ix, n;
            logic       in_limits, was_failed;
            number = data[7:0];
            n = 0;
            if (mode == bmfm_pkg::MODE_TICK) begin
                for (int m = 1; m <= MODULE_COUNT; m++) begin
                    if (m != own_module) begin
                        if (silence_count[m-1] != 16'hFFFF)
                            silence_count[m-1] = silence_count[m-1] + 16'd1;
                        if (silence_count[m-1] > silence_timeout && !failed_mark[m-1]) begin
                            failed_mark[m-1] = 1'b1;
                            push_result(bmfm_pkg::KIND_SILENT, 8'(m), 1'b0,
                                        bmfm_pkg::FAULT_NONE, 1'b0);
                            n++;
                        end
                    end
                end
            end else if (mode != MODE_UNUSED) begin
                if (number < 8'd1 || int'(number) > MODULE_COUNT) begin
                    push_result(bmfm_pkg::KIND_INVALID, number, 1'b0, bmfm_pkg::FAULT_NONE, 1'b0);
                    n = 1;
                end else begin
                    ix          = int'(number) - 1;
                    cell_a      = $signed(data[23:8]);
                    cell_b      = $signed(data[39:24]);
                    cell_c      = $signed(data[55:40]);
                    current     = $signed(data[71:56]);
                    temperature = $signed(data[87:72]);
                    was_failed  = failed_mark[ix];
                    silence_count[ix] = '0;
                    failed_mark[ix]   = 1'b0;
                    in_limits = cell_a <= int'(voltage_limit) && cell_b <= int'(voltage_limit)
                             && cell_c <= int'(voltage_limit) && current <= int'(current_limit);
                    if (mode == bmfm_pkg::MODE_REPORT_TEMP && !(temperature < int'(temp_limit)))
                        in_limits = 1'b0;
                    top    = cell_a;
                    bottom = cell_a;
                    if (cell_b > top)    top    = cell_b;
                    if (cell_c > top)    top    = cell_c;
                    if (cell_b < bottom) bottom = cell_b;
                    if (cell_c < bottom) bottom = cell_c;
                    if (!in_limits)
                        push_result(bmfm_pkg::KIND_VERDICT, own_module, 1'b0,
                                    bmfm_pkg::FAULT_LIMIT, was_failed);
                    else if (top - bottom > int'(imbalance_limit))
                        push_result(bmfm_pkg::KIND_VERDICT, own_module, 1'b0,
                                    bmfm_pkg::FAULT_IMBALANCE, was_failed);
                    else
                        push_result(bmfm_pkg::KIND_VERDICT, own_module, 1'b1,
                                    bmfm_pkg::FAULT_NONE, was_failed);
                    n = 1;
                end
            end
            if (n > 0)
                expected_results[expected_results.size() - 1].is_last = 1'b1;
        endfunction

        function void check_result(logic [MW-1:0] data, logic [1:0] kind, logic last_flag);
            monitor_result_t seen, want;
            seen = '{kind, data[7:0], data[8], data[10:9], data[11], last_flag};
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("%0t: unexpected result kind=%0d module=%0d", $time, kind, data[7:0]);
            end else begin
                want = expected_results.pop_front();
                if (seen !== want) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT) begin
                        $display("%0t: expected kind=%0d module=%0d healthy=%0d fault=%0d %s",
                                 $time, want.kind, want.module_out, want.healthy, want.fault,
                                 $sformatf("restored=%0d last=%0d", want.restored, want.is_last));
                        $display("%0t: got      kind=%0d module=%0d healthy=%0d fault=%0d %s",
                                 $time, seen.kind, seen.module_out, seen.healthy, seen.fault,
                                 $sformatf("restored=%0d last=%0d", seen.restored, seen.is_last));
                    end
                end
            end
        endfunction
    endclass

    logic                         aclk     = 1'b0;
    logic                         aresetn  = 1'b0;
    logic                         psel     = 1'b0;
    logic                         penable  = 1'b0;
    logic                         pwrite   = 1'b0;
    logic [bmfm_pkg::PADDR_W-1:0] paddr    = '0;
    logic [31:0]                  pwdata   = '0;
    logic [31:0]                  prdata;
    logic                         pready;
    logic                         s_tvalid = 1'b0;
    logic                         s_tready;
    logic [SW-1:0]                s_tdata  = '0;  // module_number, cell_a, cell_b, cell_c,
                                                  // current, temp
    logic [1:0]                   s_tuser  = '0;  // mode
    logic                         m_tvalid;
    logic                         m_tready = 1'b0;
    logic [MW-1:0]                m_tdata;        // module_out, healthy, fault_code, restored
    logic [1:0]                   m_tuser;        // kind
    logic                         m_tlast;

    int                   hold_requests = 0;
    int                   holds_done    = 0;
    int                   hold_left     = 0;
    logic [8:0]           stall_phase   = '0;
    int                   idle_cycles   = 0;
    int                   burst_left    = 0;
    fault_scoreboard      sb = new();

    battery_module_fault_monitor #(.MODULE_COUNT(MODULE_COUNT)) dut (.*);

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready)
                sb.accept_item(s_tuser, s_tdata);
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata, m_tuser, m_tlast);
        end
    end

    always @(posedge aclk) begin
        stall_phase <= stall_phase + 1'b1;
        if (hold_left != 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (holds_done != hold_requests) begin
            m_tready   <= 1'b0;
            holds_done <= hold_requests;
            hold_left  <= LONG_HOLD;
        end else begin
            case (stall_phase[8:7])
                2'd0:    m_tready <= 1'b1;
                2'd1:    m_tready <= ($urandom_range(0, 3) != 0);
                2'd2:    m_tready <= ($urandom_range(0, 1) == 1);
                default: m_tready <= (stall_phase[2:0] == 3'd0);
            endcase
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == IDLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // leaves psel high so back-to-back writes need no release in between
    task automatic reg_write(logic [2:0] idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        sb.write_reg(idx, value);
    endtask

    task automatic configure(logic [31:0] volt, logic [31:0] amps, logic [31:0] temp,
                             logic [31:0] spread, logic [31:0] timeout, logic [31:0] own);
        reg_write(bmfm_pkg::REG_VOLTAGE_LIMIT, volt);
        reg_write(bmfm_pkg::REG_CURRENT_LIMIT, amps);
        reg_write(bmfm_pkg::REG_TEMP_LIMIT, temp);
        reg_write(bmfm_pkg::REG_IMBALANCE_LIMIT, spread);
        reg_write(bmfm_pkg::REG_SILENCE_TIMEOUT, timeout);
        reg_write(bmfm_pkg::REG_OWN_MODULE, own);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic send_item(logic [1:0] mode, logic [SW-1:0] data);
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= data;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic pause(int cycles);
        s_tvalid <= 1'b0;
        repeat (cycles) @(posedge aclk);
    endtask

    // block may still be walking a quiet tick when the queue runs dry
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.expected_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    function automatic logic [SW-1:0] report_data(logic [7:0] number, int a, int b,
                                                   int c, int current, int temperature);
        return {16'(temperature), 16'(current), 16'(c), 16'(b), 16'(a), number};
    endfunction

    function automatic logic [SW-1:0] noise_data();
        logic [95:0] bits;
        bits = {$urandom, $urandom, $urandom};
        return bits[SW-1:0];
    endfunction

    task automatic send_random_item();
        int            pick, span, base, current, temperature;
        int            cells [3];
        logic [SW-1:0] data;
        if (burst_left == 0) begin
            pause($urandom_range(1, 12));
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        pick = $urandom_range(0, 99);
        if (pick < 28) begin
            send_item(bmfm_pkg::MODE_TICK, noise_data());
        end else if (pick < 34) begin
            send_item(MODE_UNUSED, noise_data());
        end else if (pick < 42) begin
            data = noise_data();
            data[7:0] = ($urandom_range(0, 3) == 0) ? 8'd0
                                                     : 8'($urandom_range(MODULE_COUNT + 1, 255));
            send_item(2'($urandom_range(0, 1)), data);
        end else begin
            span = int'(sb.imbalance_limit) + 4;
            base = int'(sb.voltage_limit) - int'($urandom_range(0, span));
            foreach (cells[i])
                cells[i] = ($urandom_range(0, 3) == 0) ? int'($urandom)
                                                        : base + int'($urandom_range(0, span));
            current = ($urandom_range(0, 1) == 1)
                    ? int'($urandom)
                    : int'(sb.current_limit) + int'($urandom_range(0, 2)) - 1;
            temperature = ($urandom_range(0, 1) == 1)
                        ? int'($urandom)
                        : int'(sb.temp_limit) + int'($urandom_range(0, 2)) - 1;
            send_item(2'($urandom_range(0, 1)),
                      report_data(8'($urandom_range(1, MODULE_COUNT)),
                                  cells[0], cells[1], cells[2], current, temperature));
        end
    endtask

    initial begin
        logic [7:0] own_pick [4];
        own_pick = '{8'd0, 8'd1, 8'd2, 8'd255};
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset limits: boundaries, precedence, invalid numbers, ignored mode, quiet ticks
        send_item(bmfm_pkg::MODE_REPORT,      report_data(8'd1, 3700, 3750, 3720, 1000, 0));
        send_item(bmfm_pkg::MODE_REPORT,      report_data(8'd1, 3600, 3800, 3700, 1000, 0));
        send_item(bmfm_pkg::MODE_REPORT,      report_data(8'd2, 3900, 4000, 3950, 2000, 0));
        send_item(bmfm_pkg::MODE_REPORT,      report_data(8'd1, 4001, 3950, 3950, 0, 0));
        send_item(bmfm_pkg::MODE_REPORT,      report_data(8'd1, 3000, 4100, 3500, 0, 0));
        send_item(bmfm_pkg::MODE_REPORT,      report_data(8'd2, 3800, 3800, 3800, 2001, 0));
        send_item(bmfm_pkg::MODE_REPORT,
                  report_data(8'd1, -32768, -32768, -32768, -32768, 32767));
        send_item(bmfm_pkg::MODE_REPORT,      report_data(8'd1, 32767, -32768, 0, 32767, -32768));
        send_item(bmfm_pkg::MODE_REPORT_TEMP, report_data(8'd1, 3800, 3800, 3800, 0, 4499));
        send_item(bmfm_pkg::MODE_REPORT_TEMP, report_data(8'd2, 3800, 3800, 3800, 0, 4500));
        send_item(bmfm_pkg::MODE_REPORT_TEMP, report_data(8'd1, 3800, 3800, 3800, 0, -32768));
        send_item(bmfm_pkg::MODE_REPORT_TEMP, report_data(8'd1, 3800, 3800, 3800, 0, 32767));
        send_item(bmfm_pkg::MODE_REPORT,      report_data(8'd0, 3800, 3800, 3800, 0, 0));
        send_item(bmfm_pkg::MODE_REPORT_TEMP, report_data(8'd3, 3800, 3800, 3800, 0, 0));
        send_item(bmfm_pkg::MODE_REPORT,      report_data(8'd255, 3800, 3800, 3800, 0, 0));
        send_item(MODE_UNUSED,                report_data(8'd1, 3800, 3800, 3800, 0, 0));
        send_item(bmfm_pkg::MODE_TICK,        noise_data());
        send_item(bmfm_pkg::MODE_TICK,        '0);

        // wide V/I, tight temp/imbalance limits, timeout 1: module 2 goes silent, then reports back
        wait_idle();
        configure(32'd32767, 32'd32767, 32'hFFFF_8000, 32'd0, 32'd1, 32'd1);
        send_item(bmfm_pkg::MODE_TICK,        noise_data());
        send_item(bmfm_pkg::MODE_TICK,        noise_data());
        send_item(bmfm_pkg::MODE_REPORT,      report_data(8'd2, 100, 100, 100, 0, 0));
        send_item(bmfm_pkg::MODE_REPORT_TEMP, report_data(8'd1, 100, 100, 100, 0, 32767));
        repeat (30) send_random_item();

        // tightest voltage and current limits, widest temperature and imbalance limits, timeout 65534
        wait_idle();
        configure(32'd0, 32'd0, 32'd32767, 32'd32767, 32'd65534, 32'd0);
        send_item(bmfm_pkg::MODE_REPORT, report_data(8'd1, 0, -32768, 0, -5, 0));
        send_item(bmfm_pkg::MODE_REPORT, report_data(8'd2, 0, 0, 0, 0, 0));
        repeat (4) send_item(bmfm_pkg::MODE_TICK, noise_data());
        repeat (15) send_random_item();

        // mid-range limits with a long receiver hold and one full drain
        wait_idle();
        configure(32'($urandom_range(3000, 4200)), 32'($urandom_range(0, 4000)),
                  32'(int'($urandom_range(0, 8000)) - 2000), 32'($urandom_range(0, 300)),
                  32'($urandom_range(1, 4)), 32'(own_pick[$urandom_range(0, 3)]));
        for (int i = 0; i < 50; i++) begin
            if (i == 5)
                hold_requests <= hold_requests + 1;
            if (i == 30)
                wait_idle();
            send_random_item();
        end

        wait_idle();
        if (sb.mismatches == 0 && sb.expected_results.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
